// ===== hdl/fragment_header_parser_core_macros.svh =====
// assertion macros used by the checker file
`ifndef FRAGMENT_HEADER_PARSER_CORE_MACROS_SVH
`define FRAGMENT_HEADER_PARSER_CORE_MACROS_SVH

// immediate implication, sampled on the rising clock edge
`define FHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define FHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fhp_pkg.sv =====
// types and constants of the fragment header parser
package fhp_pkg;

  localparam int unsigned DataCapacity = 1000;
  localparam int unsigned ScanLimit    = DataCapacity - 1;
  localparam int unsigned CountMax     = 65535;

  localparam logic [7:0] Separator = 8'h3A;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] DigitNine = 8'h39;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned LenW   = 10;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_NAME     = 3'd1,
    KIND_NAME_END = 3'd2,
    KIND_DATA     = 3'd3,
    KIND_ERROR    = 3'd4
  } item_kind_e;

  typedef enum logic [2:0] {
    PH_TOTAL = 3'd0,
    PH_FRAG  = 3'd1,
    PH_SIZE  = 3'd2,
    PH_NAME  = 3'd3,
    PH_DATA  = 3'd4,
    PH_IDLE  = 3'd5
  } phase_e;

endpackage

// ===== hdl/fhp_in_if.sv =====
// byte input channel
interface fhp_in_if
  import fhp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  in_byte;
  logic              packet_start;

  modport source (output valid, output in_byte, output packet_start, input ready);
  modport sink   (input valid, input in_byte, input packet_start, output ready);
endinterface

// ===== hdl/fhp_out_if.sv =====
// result channel
interface fhp_out_if
  import fhp_pkg::*;
;
  logic              valid;
  logic              ready;
  item_kind_e        item_kind;
  logic [ByteW-1:0]  out_byte;
  logic [CountW-1:0] total_fragments;
  logic [CountW-1:0] fragment_number;
  logic [LenW-1:0]   data_length;
  logic              last_of_packet;

  modport source (output valid, output item_kind, output out_byte, output total_fragments,
                  output fragment_number, output data_length, output last_of_packet,
                  input ready);
  modport sink   (input valid, input item_kind, input out_byte, input total_fragments,
                  input fragment_number, input data_length, input last_of_packet,
                  output ready);
endinterface

// ===== hdl/fhp_digit_acc.sv =====
// saturating decimal accumulate: acc * 10 + digit, capped
module fhp_digit_acc #(
  parameter int unsigned Width = 16,
  parameter int unsigned Cap   = 65535
) (
  input  logic [Width-1:0] acc_i,
  input  logic [3:0]       digit_i,
  output logic [Width-1:0] acc_o
);
  localparam int unsigned    WideW = Width + 4;
  localparam logic [WideW-1:0] CapW = WideW'(Cap);

  logic [WideW-1:0] wide;

  // times eight plus times two plus the digit
  assign wide  = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + {{(WideW-4){1'b0}}, digit_i};
  assign acc_o = (wide > CapW) ? Width'(Cap) : wide[Width-1:0];
endmodule

// ===== hdl/fragment_header_parser_core.sv =====
// fragment header parser: byte-serial datagram header decode and payload pass-through
// an accepted byte's result, if it has one, is registered and offered on the result channel in the next cycle
// throughput: one byte per cycle; the only limit is the single result register
// reset: asynchronous, active low; parser returns to the first number, result register empty
// a byte flagged packet_start restarts parsing and is itself parsed as position zero
module fragment_header_parser_core
  import fhp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fhp_in_if.sink    in_i,
  fhp_out_if.source out_o
);

  // parser state
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] frag_q, frag_d;
  logic [LenW-1:0]   size_q, size_d;
  logic              stopped_q, stopped_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   remain_q, remain_d;

  // result register
  logic              out_valid_q, out_valid_d;
  item_kind_e        kind_q, kind_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [CountW-1:0] otot_q, otot_d;
  logic [CountW-1:0] ofrag_q, ofrag_d;
  logic [LenW-1:0]   olen_q, olen_d;
  logic              olast_q, olast_d;
  logic              emit;

  // state as seen by this byte, after an optional restart
  phase_e            cur_phase;
  logic [CountW-1:0] cur_total;
  logic [CountW-1:0] cur_frag;
  logic [LenW-1:0]   cur_size;
  logic              cur_stopped;
  logic [LenW-1:0]   cur_pos;
  logic [LenW-1:0]   cur_remain;

  logic              in_fire;
  logic              is_colon;
  logic              is_digit;
  logic [3:0]        digit;
  logic [CountW-1:0] total_acc;
  logic [CountW-1:0] frag_acc;
  logic [LenW-1:0]   size_acc;
  logic [LenW-1:0]   remain_dec;
  logic              name_end_ok;
  logic              scan_over;

  // the result slot frees up in the same cycle its transaction completes
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign cur_phase   = in_i.packet_start ? PH_TOTAL : phase_q;
  assign cur_total   = in_i.packet_start ? '0 : total_q;
  assign cur_frag    = in_i.packet_start ? '0 : frag_q;
  assign cur_size    = in_i.packet_start ? '0 : size_q;
  assign cur_stopped = in_i.packet_start ? 1'b0 : stopped_q;
  assign cur_pos     = in_i.packet_start ? '0 : pos_q;
  assign cur_remain  = in_i.packet_start ? '0 : remain_q;

  assign is_colon = (in_i.in_byte == Separator);
  assign is_digit = (in_i.in_byte >= DigitZero) && (in_i.in_byte <= DigitNine);
  assign digit    = 4'(in_i.in_byte - DigitZero);

  // one accumulator per number, only the one for the current phase is kept
  fhp_digit_acc #(.Width(CountW), .Cap(CountMax)) u_total_acc (
    .acc_i   (cur_total),
    .digit_i (digit),
    .acc_o   (total_acc)
  );

  fhp_digit_acc #(.Width(CountW), .Cap(CountMax)) u_frag_acc (
    .acc_i   (cur_frag),
    .digit_i (digit),
    .acc_o   (frag_acc)
  );

  fhp_digit_acc #(.Width(LenW), .Cap(DataCapacity)) u_size_acc (
    .acc_i   (cur_size),
    .digit_i (digit),
    .acc_o   (size_acc)
  );

  // header scan window: the fourth colon is honoured below the limit,
  // anything else from one short of the limit onwards is malformed
  assign name_end_ok = ({1'b0, cur_pos} < (LenW+1)'(ScanLimit));
  assign scan_over   = (({1'b0, cur_pos} + (LenW+1)'(1)) >= (LenW+1)'(ScanLimit));
  assign remain_dec  = (cur_remain != '0) ? (cur_remain - LenW'(1)) : cur_remain;

  always_comb begin
    phase_d   = cur_phase;
    total_d   = cur_total;
    frag_d    = cur_frag;
    size_d    = cur_size;
    stopped_d = cur_stopped;
    pos_d     = cur_pos;
    remain_d  = cur_remain;

    emit    = 1'b0;
    kind_d  = KIND_HEADER;
    byte_d  = '0;
    otot_d  = '0;
    ofrag_d = '0;
    olen_d  = '0;
    olast_d = 1'b0;

    case (cur_phase)
      PH_IDLE: begin
        // everything dropped until the next packet start
      end
      PH_DATA: begin
        remain_d = remain_dec;
        emit     = 1'b1;
        kind_d   = KIND_DATA;
        byte_d   = in_i.in_byte;
        olast_d  = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // header phases: position saturates at the top of its range
        if (cur_pos != '1) begin
          pos_d = cur_pos + LenW'(1);
        end
        if (cur_phase == PH_NAME && is_colon && name_end_ok) begin
          emit   = 1'b1;
          kind_d = KIND_NAME_END;
          if (cur_size == '0) begin
            phase_d = PH_IDLE;
            olast_d = 1'b1;
          end else begin
            phase_d  = PH_DATA;
            remain_d = cur_size;
          end
        end else if (scan_over) begin
          emit    = 1'b1;
          kind_d  = KIND_ERROR;
          phase_d = PH_IDLE;
        end else if (cur_phase == PH_NAME) begin
          emit   = 1'b1;
          kind_d = KIND_NAME;
          byte_d = in_i.in_byte;
        end else if (is_colon) begin
          stopped_d = 1'b0;
          case (cur_phase)
            PH_TOTAL: phase_d = PH_FRAG;
            PH_FRAG:  phase_d = PH_SIZE;
            default: begin
              // third colon closes the numbers
              phase_d = PH_NAME;
              emit    = 1'b1;
              kind_d  = KIND_HEADER;
              otot_d  = cur_total;
              ofrag_d = cur_frag;
              olen_d  = cur_size;
            end
          endcase
        end else if (!cur_stopped && is_digit) begin
          case (cur_phase)
            PH_TOTAL: total_d = total_acc;
            PH_FRAG:  frag_d  = frag_acc;
            default:  size_d  = size_acc;
          endcase
        end else begin
          // first non-digit ends the number, rest up to the colon is skipped
          stopped_d = 1'b1;
        end
      end
    endcase
  end

  // a result is loaded only when the slot is free or draining this cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TOTAL;
      total_q     <= '0;
      frag_q      <= '0;
      size_q      <= '0;
      stopped_q   <= 1'b0;
      pos_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q   <= phase_d;
        total_q   <= total_d;
        frag_q    <= frag_d;
        size_q    <= size_d;
        stopped_q <= stopped_d;
        pos_q     <= pos_d;
        remain_q  <= remain_d;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      otot_q  <= otot_d;
      ofrag_q <= ofrag_d;
      olen_q  <= olen_d;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.item_kind       = kind_q;
  assign out_o.out_byte        = byte_q;
  assign out_o.total_fragments = otot_q;
  assign out_o.fragment_number = ofrag_q;
  assign out_o.data_length     = olen_q;
  assign out_o.last_of_packet  = olast_q;

endmodule

// ===== hdl/fhp_checker.sv =====
// port-level checks of the fragment header parser and their binding
`include "fragment_header_parser_core_macros.svh"

module fhp_checker
  import fhp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input item_kind_e        item_kind_i,
  input logic [ByteW-1:0]  out_byte_i,
  input logic [CountW-1:0] total_fragments_i,
  input logic [CountW-1:0] fragment_number_i,
  input logic [LenW-1:0]   data_length_i,
  input logic              last_of_packet_i
);

  // a stalled transaction keeps its payload
  `FHP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(item_kind_i) && $stable(out_byte_i) && $stable(last_of_packet_i),
    "result changed while stalled")

  // a full, stalled result slot blocks an offered byte
  `FHP_ASSERT_IMP(a_in_blocked, clk_i, rst_ni, in_valid_i && out_valid_i && !out_ready_i,
    !in_ready_i, "byte taken while result slot full")

  // numbers only ride on header transactions, size within capacity
  `FHP_ASSERT_IMP(a_numbers, clk_i, rst_ni, out_valid_i && item_kind_i != KIND_HEADER,
    total_fragments_i == '0 && fragment_number_i == '0 && data_length_i == '0,
    "numbers outside header")

  `FHP_ASSERT_IMP(a_len_cap, clk_i, rst_ni, out_valid_i,
    data_length_i <= LenW'(DataCapacity), "data length beyond capacity")

  // end flag only on data or filename end
  `FHP_ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_i && last_of_packet_i,
    item_kind_i == KIND_DATA || item_kind_i == KIND_NAME_END, "end flag on wrong kind")

endmodule

bind fragment_header_parser_core fhp_checker u_fhp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .item_kind_i       (out_o.item_kind),
  .out_byte_i        (out_o.out_byte),
  .total_fragments_i (out_o.total_fragments),
  .fragment_number_i (out_o.fragment_number),
  .data_length_i     (out_o.data_length),
  .last_of_packet_i  (out_o.last_of_packet)
);
